// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // matrix size and element count
  localparam int N_ELEM = 9;
  localparam int N_PROD = 18;
  localparam int N_ROW  = 3;

endpackage

// ===== rtl/matrix3_inverse_core.sv =====
// 3x3 fixed-point matrix inverse by adjugate and determinant. One matrix is taken per
// cycle and one inverse word leaves per cycle while out_ready holds; the divider
// resolves one quotient bit per stage for each of the nine elements. Each element is
// adj * 2^FRAC_BITS / det rounded to nearest, ties away from zero, then saturated
// (saturated flag); a zero determinant gives the zero matrix with the singular flag.
// A stall at the output only holds the stages that are full, so bubbles are squeezed
// out and input is still accepted while any stage is empty.
module matrix3_inverse_core #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ELEM_WIDTH-1:0] m00,
  input  logic signed [ELEM_WIDTH-1:0] m01,
  input  logic signed [ELEM_WIDTH-1:0] m02,
  input  logic signed [ELEM_WIDTH-1:0] m10,
  input  logic signed [ELEM_WIDTH-1:0] m11,
  input  logic signed [ELEM_WIDTH-1:0] m12,
  input  logic signed [ELEM_WIDTH-1:0] m20,
  input  logic signed [ELEM_WIDTH-1:0] m21,
  input  logic signed [ELEM_WIDTH-1:0] m22,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ELEM_WIDTH-1:0] inv00,
  output logic signed [ELEM_WIDTH-1:0] inv01,
  output logic signed [ELEM_WIDTH-1:0] inv02,
  output logic signed [ELEM_WIDTH-1:0] inv10,
  output logic signed [ELEM_WIDTH-1:0] inv11,
  output logic signed [ELEM_WIDTH-1:0] inv12,
  output logic signed [ELEM_WIDTH-1:0] inv20,
  output logic signed [ELEM_WIDTH-1:0] inv21,
  output logic signed [ELEM_WIDTH-1:0] inv22,
  output logic                         singular,
  output logic                         saturated
);

  localparam int E  = ELEM_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NE = mi3_pkg::N_ELEM;
  localparam int NP = mi3_pkg::N_PROD;
  localparam int NR = mi3_pkg::N_ROW;
  localparam int PW = 2 * E;
  localparam int AW = 2 * E + 1;
  localparam int HW = 2 * E + 1;
  localparam int DW = 3 * E + 2;
  localparam int RW = 4 * E + F + 3;
  localparam int NS = E + 8;
  localparam int DIV0 = 6;
  localparam int OUTS = NS - 1;

  localparam logic [E-1:0] LIM_P = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] LIM_N = {1'b1, {(E-1){1'b0}}};

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic signed [E-1:0] a_in [NE];
  assign a_in[0] = m00;
  assign a_in[1] = m01;
  assign a_in[2] = m02;
  assign a_in[3] = m10;
  assign a_in[4] = m11;
  assign a_in[5] = m12;
  assign a_in[6] = m20;
  assign a_in[7] = m21;
  assign a_in[8] = m22;

  // stage enables: a stage loads when empty or when the one after it moves
  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[OUTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: 2x2 minor products
  logic signed [PW-1:0] s1_p [NP];
  logic signed [E-1:0]  s1_a [NR];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_p[0]  <= a_in[4] * a_in[8];
      s1_p[1]  <= a_in[5] * a_in[7];
      s1_p[2]  <= a_in[2] * a_in[7];
      s1_p[3]  <= a_in[1] * a_in[8];
      s1_p[4]  <= a_in[1] * a_in[5];
      s1_p[5]  <= a_in[2] * a_in[4];
      s1_p[6]  <= a_in[5] * a_in[6];
      s1_p[7]  <= a_in[3] * a_in[8];
      s1_p[8]  <= a_in[0] * a_in[8];
      s1_p[9]  <= a_in[2] * a_in[6];
      s1_p[10] <= a_in[2] * a_in[3];
      s1_p[11] <= a_in[0] * a_in[5];
      s1_p[12] <= a_in[3] * a_in[7];
      s1_p[13] <= a_in[4] * a_in[6];
      s1_p[14] <= a_in[1] * a_in[6];
      s1_p[15] <= a_in[0] * a_in[7];
      s1_p[16] <= a_in[0] * a_in[4];
      s1_p[17] <= a_in[1] * a_in[3];
      for (int r = 0; r < NR; r++) s1_a[r] <= a_in[r];
    end
  end

  // stage 2: adjugate
  logic signed [AW-1:0] s2_adj [NE];
  logic signed [E-1:0]  s2_a [NR];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NE; i++) begin
        s2_adj[i] <= AW'(s1_p[2*i]) - AW'(s1_p[2*i+1]);
      end
      for (int r = 0; r < NR; r++) s2_a[r] <= s1_a[r];
    end
  end

  // stage 3: first-row cofactor products, adjugate split in low and high halves
  logic signed [HW-1:0] s3_pl [NR];
  logic signed [HW-1:0] s3_ph [NR];
  logic signed [AW-1:0] s3_adj [NE];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < NR; r++) begin
        s3_pl[r] <= s2_a[r] * $signed({1'b0, s2_adj[3*r][E-1:0]});
        s3_ph[r] <= s2_a[r] * $signed(s2_adj[3*r][AW-1:E]);
      end
      for (int i = 0; i < NE; i++) s3_adj[i] <= s2_adj[i];
    end
  end

  // stage 4: determinant
  logic signed [AW-1:0] s4_adj [NE];
  logic signed [DW-1:0] s4_det;
  logic signed [DW-1:0] det_sum;

  always_comb begin
    det_sum = '0;
    for (int r = 0; r < NR; r++) begin
      det_sum = det_sum + (DW'(s3_ph[r]) <<< E) + DW'(s3_pl[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_det <= det_sum;
      for (int i = 0; i < NE; i++) s4_adj[i] <= s3_adj[i];
    end
  end

  // stage 5: magnitudes and result signs
  logic [AW-1:0] s5_absadj [NE];
  logic [DW-1:0] s5_absdet;
  logic [NE-1:0] s5_neg;
  logic          s5_zero;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_absdet <= s4_det[DW-1] ? DW'(-s4_det) : DW'(s4_det);
      s5_zero   <= (s4_det == '0);
      for (int i = 0; i < NE; i++) begin
        s5_absadj[i] <= s4_adj[i][AW-1] ? AW'(-s4_adj[i]) : AW'(s4_adj[i]);
        s5_neg[i]    <= s4_adj[i][AW-1] ^ s4_det[DW-1];
      end
    end
  end

  // stage 6: rounding numerator 2*|adj|*2^F + |det| over 2*|det|
  logic [RW-1:0] s6_num [NE];
  logic [RW-1:0] s6_d2;
  logic [NE-1:0] s6_neg;
  logic          s6_zero;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_d2   <= RW'(s5_absdet) << 1;
      s6_zero <= s5_zero;
      s6_neg  <= s5_neg;
      for (int i = 0; i < NE; i++) begin
        s6_num[i] <= (RW'(s5_absadj[i]) << (F + 1)) + RW'(s5_absdet);
      end
    end
  end

  // divider: index 0 holds the overflow check, then one quotient bit per stage
  logic [RW-1:0] d_rem  [E+1][NE];
  logic [E-1:0]  d_q    [E+1][NE];
  logic [NE-1:0] d_ovf  [E+1];
  logic [NE-1:0] d_neg  [E+1];
  logic [RW-1:0] d_d2   [E+1];
  logic          d_zero [E+1];

  always_ff @(posedge clk) begin
    if (en[DIV0]) begin
      d_d2[0]   <= s6_d2;
      d_zero[0] <= s6_zero;
      d_neg[0]  <= s6_neg;
      for (int i = 0; i < NE; i++) begin
        d_rem[0][i]  <= s6_num[i];
        d_q[0][i]    <= '0;
        d_ovf[0][i]  <= (s6_num[i] >= (s6_d2 << E));
      end
    end
  end

  for (genvar j = 0; j < E; j++) begin : g_div
    localparam int K = E - 1 - j;
    always_ff @(posedge clk) begin
      if (en[DIV0+1+j]) begin
        d_d2[j+1]   <= d_d2[j];
        d_zero[j+1] <= d_zero[j];
        d_neg[j+1]  <= d_neg[j];
        d_ovf[j+1]  <= d_ovf[j];
        for (int i = 0; i < NE; i++) begin
          if (d_rem[j][i] >= (d_d2[j] << K)) begin
            d_rem[j+1][i] <= d_rem[j][i] - (d_d2[j] << K);
            d_q[j+1][i]   <= d_q[j][i] | (E'(1) << K);
          end else begin
            d_rem[j+1][i] <= d_rem[j][i];
            d_q[j+1][i]   <= d_q[j][i];
          end
        end
      end
    end
  end

  // output stage: sign, saturation, singular case
  logic [E-1:0]  res [NE];
  logic [NE-1:0] clip;
  logic [E-1:0]  o_inv [NE];
  logic          o_sing;
  logic          o_sat;

  always_comb begin
    logic [E-1:0] q;
    logic         nq;
    logic         over;
    for (int i = 0; i < NE; i++) begin
      q    = d_q[E][i];
      nq   = d_neg[E][i] && ((q != '0) || d_ovf[E][i]);
      over = d_ovf[E][i] || (nq ? (q > LIM_N) : (q > LIM_P));
      if (d_zero[E]) begin
        res[i]  = '0;
        clip[i] = 1'b0;
      end else if (over) begin
        res[i]  = nq ? LIM_N : LIM_P;
        clip[i] = 1'b1;
      end else begin
        res[i]  = nq ? E'(-q) : q;
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUTS]) begin
      for (int i = 0; i < NE; i++) o_inv[i] <= res[i];
      o_sing <= d_zero[E];
      o_sat  <= |clip;
    end
  end

  assign inv00     = $signed(o_inv[0]);
  assign inv01     = $signed(o_inv[1]);
  assign inv02     = $signed(o_inv[2]);
  assign inv10     = $signed(o_inv[3]);
  assign inv11     = $signed(o_inv[4]);
  assign inv12     = $signed(o_inv[5]);
  assign inv20     = $signed(o_inv[6]);
  assign inv21     = $signed(o_inv[7]);
  assign inv22     = $signed(o_inv[8]);
  assign singular  = o_sing;
  assign saturated = o_sat;

  a_sing_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> !saturated)
    else $error("singular word flagged saturated");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> inv00 == '0 && inv11 == '0 && inv22 == '0 && inv12 == '0)
    else $error("singular word carries nonzero elements");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input held off with an empty output stage");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word lost at pipeline entry");

endmodule
